>>> design/qsed_pkg.sv
// Shared types and constants for the quoted string escape decoder.
// Used by the decode logic, the result queue, the top level and the checker.
package qsed_pkg;

    localparam int FIFO_DEPTH = 4;

    typedef enum logic [2:0] {
        K_DATA    = 3'd0,
        K_CLOSED  = 3'd1,
        K_UNTERM  = 3'd2,
        K_BADHEX  = 3'd3,
        K_NOQUOTE = 3'd4
    } t_kind;

    typedef enum logic [5:0] {
        M_IDLE = 6'b000001,
        M_BODY = 6'b000010,
        M_ESC  = 6'b000100,
        M_HEX0 = 6'b001000,
        M_HEX1 = 6'b010000,
        M_OCT  = 6'b100000
    } t_mode;

    typedef struct packed {
        logic [7:0] data;
        t_kind      kind;
        logic       last;
    } t_result;

    typedef struct packed {
        t_mode      mode;
        logic [7:0] val;
        logic [1:0] cnt;
    } t_state;

    typedef struct packed {
        logic [1:0] num;
        t_result    r0;
        t_result    r1;
        t_state     nxt;
    } t_step;

endpackage

>>> design/qsed_decode.sv
// Combinational step of the decoder: one source byte and the current state
// give up to two result words and the next state. Depends on qsed_pkg.
module qsed_decode (
    input  qsed_pkg::t_state i_state,
    input  logic [7:0]       i_byte,
    output qsed_pkg::t_step  o_step
);
    import qsed_pkg::*;

    typedef struct packed {
        logic    emit;
        t_result res;
        t_mode   mode;
    } t_body;

    function automatic t_result mk(input logic [7:0] d, input t_kind k);
        t_result r;
        r.data = d;
        r.kind = k;
        r.last = 1'b0;
        return r;
    endfunction

    // Plain string byte: close, end of input, start of escape, or data.
    function automatic t_body body_step(input logic [7:0] b);
        t_body o;
        o.emit = 1'b1;
        o.res  = mk(b, K_DATA);
        o.mode = M_BODY;
        if (b == 8'd0) begin
            o.res  = mk(8'd0, K_UNTERM);
            o.mode = M_IDLE;
        end else if (b == 8'h22) begin
            o.res  = mk(8'd0, K_CLOSED);
            o.mode = M_IDLE;
        end else if (b == 8'h5c) begin
            o.emit = 1'b0;
            o.mode = M_ESC;
        end
        return o;
    endfunction

    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, 4'(b - 8'h57)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

    function automatic logic [8:0] simple_escape(input logic [7:0] b);
        logic [8:0] r;
        case (b)
            8'h6e:   r = {1'b1, 8'd10};
            8'h74:   r = {1'b1, 8'd9};
            8'h72:   r = {1'b1, 8'd13};
            8'h62:   r = {1'b1, 8'd8};
            8'h66:   r = {1'b1, 8'd12};
            8'h76:   r = {1'b1, 8'd11};
            8'h61:   r = {1'b1, 8'd7};
            8'h5c:   r = {1'b1, 8'd92};
            8'h22:   r = {1'b1, 8'd34};
            8'h27:   r = {1'b1, 8'd39};
            8'h3f:   r = {1'b1, 8'd63};
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    logic       is_oct;
    logic [4:0] hd;
    logic [8:0] se;
    logic [7:0] oct_val;
    logic [1:0] oct_cnt;
    t_body      bs;
    t_step      s;

    assign is_oct  = (i_byte >= 8'h30) && (i_byte <= 8'h37);
    assign hd      = hex_digit(i_byte);
    assign se      = simple_escape(i_byte);
    assign oct_val = {i_state.val[4:0], i_byte[2:0]};
    assign oct_cnt = i_state.cnt + 2'd1;
    assign bs      = body_step(i_byte);

    always_comb begin
        s.num = 2'd0;
        s.r0  = mk(8'd0, K_DATA);
        s.r1  = mk(8'd0, K_DATA);
        s.nxt = i_state;
        case (i_state.mode)
            M_BODY: begin
                s.num      = {1'b0, bs.emit};
                s.r0       = bs.res;
                s.nxt.mode = bs.mode;
            end
            M_ESC: begin
                if (i_byte == 8'd0) begin
                    s.nxt.mode = M_IDLE;
                    s.num      = 2'd1;
                    s.r0       = mk(8'd0, K_UNTERM);
                end else if (i_byte == 8'h78) begin
                    s.nxt.mode = M_HEX0;
                end else if (is_oct) begin
                    s.nxt.val  = {5'd0, i_byte[2:0]};
                    s.nxt.cnt  = 2'd1;
                    s.nxt.mode = M_OCT;
                end else begin
                    s.nxt.mode = M_BODY;
                    if (se[8]) begin
                        s.num = 2'd1;
                        s.r0  = mk(se[7:0], K_DATA);
                    end else begin
                        // unknown escape: keep the backslash
                        s.num = 2'd2;
                        s.r0  = mk(8'h5c, K_DATA);
                        s.r1  = mk(i_byte, K_DATA);
                    end
                end
            end
            M_HEX0: begin
                if (i_byte == 8'd0) begin
                    s.nxt.mode = M_IDLE;
                    s.num      = 2'd1;
                    s.r0       = mk(8'd0, K_UNTERM);
                end else if (!hd[4]) begin
                    s.nxt.mode = M_IDLE;
                    s.num      = 2'd1;
                    s.r0       = mk(8'd0, K_BADHEX);
                end else begin
                    s.nxt.val  = {4'd0, hd[3:0]};
                    s.nxt.mode = M_HEX1;
                end
            end
            M_HEX1: begin
                s.nxt.val = 8'd0;
                if (hd[4]) begin
                    s.num      = 2'd1;
                    s.r0       = mk({i_state.val[3:0], hd[3:0]}, K_DATA);
                    s.nxt.mode = M_BODY;
                end else begin
                    // flush the held digit, then treat the byte as body
                    s.num      = {bs.emit, ~bs.emit};
                    s.r0       = mk(i_state.val, K_DATA);
                    s.r1       = bs.res;
                    s.nxt.mode = bs.mode;
                end
            end
            M_OCT: begin
                if (is_oct) begin
                    if (oct_cnt == 2'd3) begin
                        s.num      = 2'd1;
                        s.r0       = mk(oct_val, K_DATA);
                        s.nxt.mode = M_BODY;
                        s.nxt.val  = 8'd0;
                        s.nxt.cnt  = 2'd0;
                    end else begin
                        s.nxt.val = oct_val;
                        s.nxt.cnt = oct_cnt;
                    end
                end else begin
                    s.num      = {bs.emit, ~bs.emit};
                    s.r0       = mk(i_state.val, K_DATA);
                    s.r1       = bs.res;
                    s.nxt.mode = bs.mode;
                    s.nxt.val  = 8'd0;
                    s.nxt.cnt  = 2'd0;
                end
            end
            default: begin
                s.nxt.val = 8'd0;
                s.nxt.cnt = 2'd0;
                if (i_byte == 8'h22) begin
                    s.nxt.mode = M_BODY;
                end else begin
                    s.nxt.mode = M_IDLE;
                    s.num      = 2'd1;
                    s.r0       = mk(8'd0, K_NOQUOTE);
                end
            end
        endcase
        // mark the final word of this byte
        if (s.num == 2'd1) begin
            s.r0.last = 1'b1;
        end else if (s.num == 2'd2) begin
            s.r1.last = 1'b1;
        end
    end

    assign o_step = s;

endmodule

>>> design/qsed_out_fifo.sv
// Small result queue: takes zero, one or two words per cycle, gives one when popped.
// Depends on qsed_pkg for the result word type.
module qsed_out_fifo #(
    parameter int Depth = qsed_pkg::FIFO_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [1:0]                  i_push_num,
    input  qsed_pkg::t_result           i_din0,
    input  qsed_pkg::t_result           i_din1,
    input  logic                        i_pop,
    output qsed_pkg::t_result           o_head,
    output logic                        o_valid,
    output logic [$clog2(Depth+1)-1:0]  o_count
);
    import qsed_pkg::*;

    localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CW = $clog2(Depth + 1);

    function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
        return (p == PW'(Depth - 1)) ? '0 : p + PW'(1);
    endfunction

    t_result         r_mem [Depth];
    logic [PW-1:0]   r_wp, n_wp;
    logic [PW-1:0]   r_rp, n_rp;
    logic [CW-1:0]   r_count, n_count;
    logic [PW-1:0]   wp1;
    logic            pop_ok;

    assign wp1    = inc(r_wp);
    assign pop_ok = i_pop && (r_count != '0);

    always_comb begin
        n_wp    = r_wp;
        n_rp    = pop_ok ? inc(r_rp) : r_rp;
        n_count = r_count + CW'(i_push_num) - CW'(pop_ok);
        if (i_push_num == 2'd1) begin
            n_wp = wp1;
        end else if (i_push_num == 2'd2) begin
            n_wp = inc(wp1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_num != 2'd0) begin
            r_mem[r_wp] <= i_din0;
        end
        if (i_push_num == 2'd2) begin
            r_mem[wp1] <= i_din1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    assign o_head  = r_mem[r_rp];
    assign o_valid = (r_count != '0);
    assign o_count = r_count;

endmodule

>>> design/quoted_string_escape_decoder_core.sv
// Quoted string escape decoder, top level.
// Each byte is registered, then its result words go into the queue that drives the output.
// One byte per cycle while the queue has room for two words; a byte that yields two words
// gives them out in turn, and the four-word result queue sets how far input runs ahead.
// Reset (synchronous, active low) empties the queue and input register and
// returns the decoder to waiting for an opening quote.
module quoted_string_escape_decoder_core #(
    parameter int FifoDepth = qsed_pkg::FIFO_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic [2:0] o_kind,
    output logic       o_last
);
    import qsed_pkg::*;

    localparam int CW = $clog2(FifoDepth + 1);

    logic          r_in_valid;
    logic [7:0]    r_in_byte;
    t_state        r_state;
    t_step         step;
    logic          process;
    logic [1:0]    push_num;
    logic [CW-1:0] count;
    t_result       head;

    // step only when the queue can take two words
    assign process  = r_in_valid && (count <= CW'(FifoDepth - 2));
    assign o_stall  = r_in_valid && !process;
    assign push_num = process ? step.num : 2'd0;

    qsed_decode u_decode (
        .i_state (r_state),
        .i_byte  (r_in_byte),
        .o_step  (step)
    );

    qsed_out_fifo #(
        .Depth (FifoDepth)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_num (push_num),
        .i_din0     (step.r0),
        .i_din1     (step.r1),
        .i_pop      (!i_stall),
        .o_head     (head),
        .o_valid    (o_valid),
        .o_count    (count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_state.mode  <= M_IDLE;
            r_state.val   <= 8'd0;
            r_state.cnt   <= 2'd0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (process) begin
                r_state <= step.nxt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_in_byte;
        end
    end

    assign o_out_byte = head.data;
    assign o_kind     = head.kind;
    assign o_last     = head.last;

endmodule

>>> design/qsed_checker.sv
// Port-level checks for the quoted string escape decoder, bound to the top.
// Depends on qsed_pkg for the result kind codes.
module qsed_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_out_byte,
    input logic [2:0] o_kind,
    input logic       o_last
);
    import qsed_pkg::*;

    // status words always end the byte's results
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind != K_DATA) |-> o_last)
        else $error("status word without last");

    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind != K_DATA) |-> (o_out_byte == 8'd0))
        else $error("status word carries nonzero byte");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_kind == K_DATA || o_kind == K_CLOSED || o_kind == K_UNTERM
                     || o_kind == K_BADHEX || o_kind == K_NOQUOTE))
        else $error("undefined result kind");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_out_byte) && $stable(o_kind)
                                  && $stable(o_last)))
        else $error("stalled output word changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

bind quoted_string_escape_decoder_core qsed_checker u_qsed_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_out_byte (o_out_byte),
    .o_kind     (o_kind),
    .o_last     (o_last)
);
